### hdl/ids2x_pkg.sv
// Shared types and constants for the 2x2 box-average downscaler.
package ids2x_pkg;

   // Configuration register widths and reset values
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_HEIGHT = 1'b1;

   // Row counter and height limit
   localparam int ROW_W = 12;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;

   // Width of the compare that saturates the source width
   localparam int WIDTH_CMP_W = 14;

   // Per-channel widths
   localparam int CHAN_W     = 8;
   localparam int PAIR_W     = 9;
   localparam int BLOCK_W    = 10;
   localparam logic [BLOCK_W-1:0] ROUND_BIAS = 10'd2;

   // Pixel as carried on the streams, red in the lowest bits
   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } ids2x_pixel_type;

   // Horizontal pair sums, one line buffer entry
   typedef struct packed {
      logic [PAIR_W-1:0] blue;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] red;
   } ids2x_pair_type;

   // Marks that travel with a result
   typedef struct packed {
      logic row_end;
      logic frame_end;
   } ids2x_flags_type;

endpackage

### hdl/image_downscale_2x_box_average_core.sv
// Top level of the 2x2 box-average image downscaler.
//
//   port group  dir  beat contents
//   req_*       in   tdata: in_red, in_green, in_blue
//   rsp_*       out  tdata: out_red, out_green, out_blue; tlast: row_end; tuser: frame_end
//   csr_*       in   write of source_width (index 0) or source_height (index 1)
//
// One pixel beat is taken every cycle unless the average stage stalls the input; an output
// beat follows the odd-row, odd-column beat that completes its block (line buffer read,
// then the average register). The line buffer's one write and one read port set the
// rate: a row pair is written on even rows and read back on odd rows.
// Reset clears the counters, the left pixel and the pipeline; the line buffer
// needs no clearing pass. A stalled output holds one result and one in flight.
module image_downscale_2x_box_average_core
   import ids2x_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [23:0]             req_tdata,   // in_red, in_green, in_blue
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [23:0]             rsp_tdata,   // out_red, out_green, out_blue
   output logic                    rsp_tlast,   // row_end
   output logic                    rsp_tuser,   // frame_end
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int EW         = COL_W + 1;

   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   logic [COL_W-1:0]        col_ff;
   logic [COL_W-1:0]        col_in;
   logic [ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]        row_in;
   ids2x_pixel_type         left_ff;
   ids2x_pixel_type         pix;

   logic [EW-1:0]           eff_w;
   logic [EW-1:0]           out_w;
   logic [EW-1:0]           used_w;
   logic [EW-1:0]           col_ext;
   logic [EW-1:0]           col_next;
   logic [HEIGHT_REG_W-1:0] eff_h;
   logic [HEIGHT_REG_W-1:0] used_h;
   logic [HEIGHT_REG_W-1:0] row_ext;
   logic [HEIGHT_REG_W-1:0] row_next;

   logic                    accept;
   logic                    in_block;
   logic                    line_we;
   logic                    line_re;
   logic [IDX_W-1:0]        line_idx;
   ids2x_pair_type          pair;
   ids2x_pair_type          above;
   ids2x_flags_type         flags;
   ids2x_pixel_type         out_pixel;
   ids2x_flags_type         out_flags;

   assign pix    = ids2x_pixel_type'(req_tdata);
   assign accept = req_tvalid && req_tready;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            CSR_SOURCE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the frame size: zero counts as one, oversize saturates
   always_comb begin
      if (width_ff == '0) begin
         eff_w = EW'(1);
      end else if (WIDTH_CMP_W'(width_ff) > WIDTH_CMP_W'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HEIGHT_REG_W'(1);
      end else if (height_ff > HEIGHT_LIMIT) begin
         eff_h = HEIGHT_LIMIT;
      end else begin
         eff_h = height_ff;
      end
      out_w  = eff_w >> 1;
      used_w = {eff_w[EW-1:1], 1'b0};
      used_h = {eff_h[HEIGHT_REG_W-1:1], 1'b0};
   end

   // Decode the position of the current beat
   always_comb begin
      col_ext  = EW'(col_ff);
      row_ext  = HEIGHT_REG_W'(row_ff);
      col_next = col_ext + EW'(1);
      row_next = row_ext + HEIGHT_REG_W'(1);
      in_block = col_ff[0] && (col_ext < used_w) && (row_ext < used_h);
      line_we  = accept && in_block && !row_ff[0];
      line_re  = accept && in_block && row_ff[0];
      line_idx = IDX_W'(col_ff >> 1);
      pair.red   = PAIR_W'(left_ff.red)   + PAIR_W'(pix.red);
      pair.green = PAIR_W'(left_ff.green) + PAIR_W'(pix.green);
      pair.blue  = PAIR_W'(left_ff.blue)  + PAIR_W'(pix.blue);
      flags.row_end   = (EW'(col_ff >> 1) == (out_w - EW'(1)));
      flags.frame_end = flags.row_end && (row_ext == (used_h - HEIGHT_REG_W'(1)));
   end

   // Advance the raster counters, wrapping at the last column and row
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= eff_w) begin
            col_in = '0;
            row_in = (row_next >= eff_h) ? '0 : ROW_W'(row_next);
         end else begin
            col_in = COL_W'(col_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         left_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept && !col_ff[0]) begin
            left_ff <= pix;
         end
      end
   end

   ids2x_line_buf #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_idx),
      .wr_data (pair),
      .rd_en   (line_re),
      .rd_addr (line_idx),
      .rd_data (above)
   );

   ids2x_average u_average (
      .clock      (clock),
      .reset      (reset),
      .issue      (line_re),
      .pair       (pair),
      .flags      (flags),
      .above      (above),
      .take_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_pixel  (out_pixel),
      .out_flags  (out_flags)
   );

   assign rsp_tdata = out_pixel;
   assign rsp_tlast = out_flags.row_end;
   assign rsp_tuser = out_flags.frame_end;

`ifndef ASSERT_OFF
   // One beat touches the line buffer at most once
   assert property (@(posedge clock) disable iff (reset) !(line_we && line_re))
      else $error("line buffer written and read by the same beat");

   // Frame end only on the last pixel of a row
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("frame end without row end");

   // Input stalls only while a result waits at the output
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output");

   // A line read always yields a result beat
   assert property (@(posedge clock) disable iff (reset)
      line_re |=> ##1 rsp_tvalid)
      else $error("line read lost its result");
`endif

endmodule

### hdl/ids2x_line_buf.sv
// Line buffer holding the pair sums of the last even source row.
module ids2x_line_buf
   import ids2x_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  ids2x_pair_type       wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output ids2x_pair_type       rd_data
);

   ids2x_pair_type mem [DEPTH];
   ids2x_pair_type rd_data_ff;

   // Write pair sums from even rows
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read the stored sums for odd rows; hold the data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/ids2x_average.sv
// Block average stage and result register with stall handling.
module ids2x_average
   import ids2x_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              issue,
   input  ids2x_pair_type    pair,
   input  ids2x_flags_type   flags,
   input  ids2x_pair_type    above,
   output logic              take_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output ids2x_pixel_type   out_pixel,
   output ids2x_flags_type   out_flags
);

   logic            s1_valid_ff;
   logic            s1_valid_in;
   ids2x_pair_type  s1_pair_ff;
   ids2x_flags_type s1_flags_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   ids2x_pixel_type out_pixel_ff;
   ids2x_pixel_type out_pixel_in;
   ids2x_flags_type out_flags_ff;
   logic            out_free;
   logic [BLOCK_W-1:0] sum_red;
   logic [BLOCK_W-1:0] sum_green;
   logic [BLOCK_W-1:0] sum_blue;

   // Result register frees up when empty or drained this cycle
   assign out_free   = !out_valid_ff || out_ready;
   assign take_ready = !s1_valid_ff || out_free;

   // Add the stored row pair to this row pair and round
   always_comb begin
      sum_red   = BLOCK_W'(above.red)   + BLOCK_W'(s1_pair_ff.red)   + ROUND_BIAS;
      sum_green = BLOCK_W'(above.green) + BLOCK_W'(s1_pair_ff.green) + ROUND_BIAS;
      sum_blue  = BLOCK_W'(above.blue)  + BLOCK_W'(s1_pair_ff.blue)  + ROUND_BIAS;
      out_pixel_in.red   = sum_red[BLOCK_W-1:2];
      out_pixel_in.green = sum_green[BLOCK_W-1:2];
      out_pixel_in.blue  = sum_blue[BLOCK_W-1:2];
   end

   // Stage and result valid bits
   always_comb begin
      s1_valid_in  = take_ready ? issue : s1_valid_ff;
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the stage on a new item; hold it while stalled
   always_ff @(posedge clock) begin
      if (take_ready && issue) begin
         s1_pair_ff  <= pair;
         s1_flags_ff <= flags;
      end
   end

   // Advance into the result register when it frees up
   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
         out_flags_ff <= s1_flags_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;
   assign out_flags = out_flags_ff;

endmodule

### tb/image_downscale_2x_box_average_core_tb.sv
// Testbench for the 2x2 box-average downscaler: directed table, random frames, beat checker.
module image_downscale_2x_box_average_core_tb;
   import ids2x_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 10;
   localparam int MAX_COLUMNS  = 2048;
   localparam int LINE_DEPTH   = MAX_COLUMNS / 2;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_CYCLES = 4;

   // One output beat: averaged pixel plus its row and frame marks
   typedef struct packed {
      ids2x_pixel_type pixel;
      ids2x_flags_type flags;
   } avg_beat_type;

   typedef enum logic {PLAN_PIXEL, PLAN_WRITE} plan_kind_type;

   typedef struct {
      plan_kind_type             kind;
      logic [CSR_INDEX_W-1:0]    index;
      logic [CSR_DATA_W-1:0]     value;
      ids2x_pixel_type           pixel;
      bit                        pinned;
      avg_beat_type              want;
   } plan_step_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [23:0]             req_tdata = '0;    // in_red, in_green, in_blue
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [23:0]             rsp_tdata;         // out_red, out_green, out_blue
   logic                    rsp_tlast;         // row_end
   logic                    rsp_tuser;         // frame_end
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Predictor state: registers, line of pair sums, left pixel and raster position
   logic [WIDTH_REG_W-1:0]  width_reg = WIDTH_RESET;
   logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
   ids2x_pair_type          pair_line [LINE_DEPTH];
   bit                      line_written [LINE_DEPTH];
   ids2x_pixel_type         left_px = '0;
   logic [10:0]             col_pos = '0;
   logic [ROW_W-1:0]        row_pos = '0;

   avg_beat_type            pending_avgs [$];
   avg_beat_type            pinned_avgs [int];
   plan_step_type           plan [$];
   int                      pixels_taken = 0;
   int                      mismatch_count = 0;
   int                      quiet_cycles = 0;
   int                      gap_pct = 0;
   int                      stall_pct = 0;

   image_downscale_2x_box_average_core #(
      .MAX_WIDTH (MAX_COLUMNS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int eff_width(input logic [WIDTH_REG_W-1:0] w);
      if (w == 0) return 1;
      if (int'(w) > MAX_COLUMNS) return MAX_COLUMNS;
      return int'(w);
   endfunction

   function automatic int eff_height(input logic [HEIGHT_REG_W-1:0] h);
      if (h == 0) return 1;
      if (h > HEIGHT_LIMIT) return int'(HEIGHT_LIMIT);
      return int'(h);
   endfunction

   // Advance the downscaler by one source pixel; returns 1 when a block completes
   function automatic bit downscale_pixel(input ids2x_pixel_type px, output avg_beat_type beat);
      int                 w, h, out_w, used_h, idx;
      ids2x_pair_type     pair, above;
      logic [BLOCK_W-1:0] sum_r, sum_g, sum_b;
      bit                 hit;
      w = eff_width(width_reg);
      h = eff_height(height_reg);
      out_w = w / 2;
      used_h = (h / 2) * 2;
      idx = int'(col_pos) / 2;
      hit = 1'b0;
      beat = '0;
      if (!col_pos[0]) begin
         left_px = px;
      end else if (int'(col_pos) < out_w * 2 && int'(row_pos) < used_h) begin
         pair.red   = PAIR_W'(left_px.red) + PAIR_W'(px.red);
         pair.green = PAIR_W'(left_px.green) + PAIR_W'(px.green);
         pair.blue  = PAIR_W'(left_px.blue) + PAIR_W'(px.blue);
         if (!row_pos[0]) begin
            pair_line[idx] = pair;
            line_written[idx] = 1'b1;
         end else begin
            above = pair_line[idx];
            sum_r = BLOCK_W'(above.red) + BLOCK_W'(pair.red) + ROUND_BIAS;
            sum_g = BLOCK_W'(above.green) + BLOCK_W'(pair.green) + ROUND_BIAS;
            sum_b = BLOCK_W'(above.blue) + BLOCK_W'(pair.blue) + ROUND_BIAS;
            beat.pixel.red   = sum_r[BLOCK_W-1:2];
            beat.pixel.green = sum_g[BLOCK_W-1:2];
            beat.pixel.blue  = sum_b[BLOCK_W-1:2];
            beat.flags.row_end = (idx == out_w - 1);
            beat.flags.frame_end = beat.flags.row_end && (int'(row_pos) == used_h - 1);
            hit = 1'b1;
         end
      end
      // step the raster position, wrapping at the last column and row
      if (int'(col_pos) + 1 >= w) begin
         col_pos = '0;
         row_pos = (int'(row_pos) + 1 >= h) ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
      return hit;
   endfunction

   function automatic plan_step_type pixel_step(input ids2x_pixel_type px, input bit pin = 1'b0,
                                                input avg_beat_type want = '0);
      plan_step_type s;
      s.kind = PLAN_PIXEL;
      s.index = CSR_SOURCE_WIDTH;
      s.value = '0;
      s.pixel = px;
      s.pinned = pin;
      s.want = want;
      return s;
   endfunction

   function automatic plan_step_type write_step(input logic [CSR_INDEX_W-1:0] index,
                                                input logic [CSR_DATA_W-1:0] value);
      plan_step_type s;
      s = pixel_step('0);
      s.kind = PLAN_WRITE;
      s.index = index;
      s.value = value;
      return s;
   endfunction

   // Extremes appear more often than a flat draw would give them
   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic send_pixel(input ids2x_pixel_type px);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold off until every expected beat is out, then let the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_avgs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random frames of mostly small sizes, some cut short so the next write lands mid-frame
   task automatic random_run(input int budget);
      int sent, w, h, n, span;
      sent = 0;
      while (sent < budget) begin
         drain();
         case ($urandom_range(9))
            0: w = $urandom_range(1);
            1: w = $urandom_range(40, 13);
            default: w = $urandom_range(12, 2);
         endcase
         h = ($urandom_range(7) == 0) ? $urandom_range(1) : $urandom_range(8, 2);
         // inside a frame, widen only over line entries that an even row already filled
         if (col_pos != 0 || row_pos != 0) begin
            span = 0;
            while (span < LINE_DEPTH && line_written[span]) span++;
            if (eff_width(12'(w)) / 2 > span) w = 2 * span + $urandom_range(1);
         end
         write_reg(CSR_SOURCE_WIDTH, {1'($urandom_range(7) == 0), 12'(w)});
         write_reg(CSR_SOURCE_HEIGHT, 13'(h));
         n = eff_width(12'(w)) * eff_height(13'(h)) * $urandom_range(2, 1);
         if ($urandom_range(4) == 0) n = $urandom_range(n, 1);
         repeat (n) begin
            send_pixel({random_channel(), random_channel(), random_channel()});
            sent++;
         end
      end
   endtask

   // Receiver side: drop tready at the current stall rate
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Track register writes, check output beats, predict from input beats, watch for hangs
   always @(posedge clock) begin
      avg_beat_type got, exp_beat, beat;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_SOURCE_WIDTH) width_reg = csr_wdata[WIDTH_REG_W-1:0];
            else height_reg = csr_wdata[HEIGHT_REG_W-1:0];
         end
         if (rsp_tvalid && rsp_tready) begin
            got.pixel = rsp_tdata;
            got.flags.row_end = rsp_tlast;
            got.flags.frame_end = rsp_tuser;
            if (pending_avgs.size() == 0) begin
               $display("%0t: unexpected beat: expected none, got %h", $time, got);
               mismatch_count++;
            end else begin
               exp_beat = pending_avgs.pop_front();
               check_field("out_red", exp_beat.pixel.red, got.pixel.red);
               check_field("out_green", exp_beat.pixel.green, got.pixel.green);
               check_field("out_blue", exp_beat.pixel.blue, got.pixel.blue);
               check_field("row_end", exp_beat.flags.row_end, got.flags.row_end);
               check_field("frame_end", exp_beat.flags.frame_end, got.flags.frame_end);
            end
         end
         if (req_tvalid && req_tready) begin
            if (downscale_pixel(req_tdata, beat) && !pinned_avgs.exists(pixels_taken))
               pending_avgs.push_back(beat);
            if (pinned_avgs.exists(pixels_taken)) pending_avgs.push_back(pinned_avgs[pixels_taken]);
            pixels_taken++;
         end
         if (csr_we || (rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
               $display("status: fail");
               $finish;
            end
         end
      end
   end

   initial begin
      int seq;
      // partial row at reset size, then shrink to 2x2 mid-frame: column wraps at once
      plan.push_back(pixel_step(24'hFFFFFF));
      plan.push_back(pixel_step(24'hFFFFFF));
      plan.push_back(pixel_step(24'h000000));
      plan.push_back(write_step(CSR_SOURCE_WIDTH, 13'd2));
      plan.push_back(write_step(CSR_SOURCE_HEIGHT, 13'd2));
      plan.push_back(pixel_step(24'h5A5A5A));
      plan.push_back(pixel_step(24'hFFFFFF));
      plan.push_back(pixel_step(24'hFFFFFF, 1'b1, {24'hFFFFFF, 2'b11}));
      // all-zero block
      plan.push_back(pixel_step(24'h000000));
      plan.push_back(pixel_step(24'h000000));
      plan.push_back(pixel_step(24'h000000));
      plan.push_back(pixel_step(24'h000000, 1'b1, {24'h000000, 2'b11}));
      // rounding on each channel
      plan.push_back(pixel_step(24'hFE0101));
      plan.push_back(pixel_step(24'hFF0100));
      plan.push_back(pixel_step(24'hFF0000));
      plan.push_back(pixel_step(24'hFF0000));
      // zero width and height count as one: no output at all
      plan.push_back(write_step(CSR_SOURCE_WIDTH, 13'd0));
      plan.push_back(write_step(CSR_SOURCE_HEIGHT, 13'd0));
      plan.push_back(pixel_step(24'h808080));
      plan.push_back(pixel_step(24'h7F7F7F));
      // odd width and height: last column and row dropped
      plan.push_back(write_step(CSR_SOURCE_WIDTH, 13'd3));
      plan.push_back(write_step(CSR_SOURCE_HEIGHT, 13'd3));
      plan.push_back(pixel_step(24'h010203));
      plan.push_back(pixel_step(24'hFDFEFF));
      plan.push_back(pixel_step(24'h800080));
      plan.push_back(pixel_step(24'h7F7F7F));
      plan.push_back(pixel_step(24'h00FF00));
      plan.push_back(pixel_step(24'hFF00FF));
      plan.push_back(pixel_step(24'h123456));
      plan.push_back(pixel_step(24'hABCDEF));
      plan.push_back(pixel_step(24'h000001));

      // key the typed-in results by pixel beat number
      seq = 0;
      foreach (plan[i]) begin
         if (plan[i].kind == PLAN_PIXEL) begin
            if (plan[i].pinned) pinned_avgs[seq] = plan[i].want;
            seq++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct = 22;
      stall_pct = 71;
      foreach (plan[i]) begin
         if (plan[i].kind == PLAN_WRITE) begin
            drain();
            write_reg(plan[i].index, plan[i].value);
         end else begin
            send_pixel(plan[i].pixel);
         end
      end

      // oversized width saturates to the full line: a short run into a 2048-wide row
      drain();
      write_reg(CSR_SOURCE_WIDTH, 13'd4095);
      write_reg(CSR_SOURCE_HEIGHT, 13'd2);
      repeat (48) send_pixel({random_channel(), random_channel(), random_channel()});

      // oversized height saturates to 4096 rows; one-column rows give no output
      drain();
      write_reg(CSR_SOURCE_WIDTH, 13'd1);
      write_reg(CSR_SOURCE_HEIGHT, 13'd8191);
      repeat (24) send_pixel({random_channel(), random_channel(), random_channel()});

      random_run(400);
      gap_pct = 71;
      stall_pct = 22;
      random_run(400);
      gap_pct = 0;
      stall_pct = 0;
      random_run(400);

      drain();
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
